// ----- design/rsm_pkg.sv -----
// rsm_pkg: shared types and constants for the route summing mixer with null meter
// no dependencies; used by the interfaces, the top level and the checker
`default_nettype none

package rsm_pkg;

   typedef logic signed [23:0] sample_type;
   typedef logic signed [11:0] level_type;

   // request codes
   localparam logic [1:0] REQ_ROUTE = 2'd0;
   localparam logic [1:0] REQ_REF   = 2'd1;
   localparam logic [1:0] REQ_EOB   = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_AUDIO = 3'd0;
   localparam logic [2:0] KIND_REF   = 3'd1;
   localparam logic [2:0] KIND_SUM   = 3'd2;
   localparam logic [2:0] KIND_NULL  = 3'd3;
   localparam logic [2:0] KIND_ROUTE = 3'd4;

   // monitor modes
   localparam logic [1:0] MODE_REF = 2'd0;
   localparam logic [1:0] MODE_SUM = 2'd1;

   // register indexes
   localparam logic [1:0] REG_MODE  = 2'd0;
   localparam logic [1:0] REG_COUNT = 2'd1;

   localparam level_type         DB_FLOOR   = -12'sd1200;
   localparam logic signed [23:0] K_POW     = 24'sd1972830;
   localparam logic signed [23:0] K_AMP     = 24'sd3945660;
   localparam logic signed [23:0] RMS_BIAS  = 24'sd3014656;  // 46 in q16
   localparam logic signed [23:0] PEAK_BIAS = 24'sd1507328;  // 23 in q16
   localparam logic [15:0]       MAX_FRAMES = 16'd4096;

   typedef enum logic [12:0] {
      ST_IDLE    = 13'b0000000000001,
      ST_RT_WR   = 13'b0000000000010,
      ST_REF_MUL = 13'b0000000000100,
      ST_REF_ACC = 13'b0000000001000,
      ST_REF_OUT = 13'b0000000010000,
      ST_E_PREP  = 13'b0000000100000,
      ST_E_NEXT  = 13'b0000001000000,
      ST_E_RDW   = 13'b0000010000000,
      ST_NORM    = 13'b0000100000000,
      ST_SQ_MUL  = 13'b0001000000000,
      ST_SQ_UPD  = 13'b0010000000000,
      ST_SC_MUL  = 13'b0100000000000,
      ST_SC_FIN  = 13'b1000000000000
   } state_type;

endpackage

`default_nettype wire

// ----- design/rsm_if.sv -----
// rsm channel interfaces: request, response and register write channels
// depends on rsm_pkg
`default_nettype none

interface rsm_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   logic [4:0]          route_index;
   rsm_pkg::sample_type left_sample;
   rsm_pkg::sample_type right_sample;
   logic                ref_present;
   modport source (output valid, req_type, route_index, left_sample, right_sample,
                   ref_present, input ready);
   modport sink (input valid, req_type, route_index, left_sample, right_sample,
                 ref_present, output ready);
endinterface

interface rsm_rsp_if;
   logic                valid;
   logic                ready;
   logic [2:0]          kind;
   logic [4:0]          route_out;
   rsm_pkg::sample_type out_left;
   rsm_pkg::sample_type out_right;
   rsm_pkg::level_type  rms_db;
   rsm_pkg::level_type  peak_db;
   logic [5:0]          live_count;
   logic                last;
   modport source (output valid, kind, route_out, out_left, out_right, rms_db, peak_db,
                   live_count, last, input ready);
   modport sink (input valid, kind, route_out, out_left, out_right, rms_db, peak_db,
                 live_count, last, output ready);
endinterface

interface rsm_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] csr_index;
   logic [5:0] csr_data;
   modport source (output valid, csr_index, csr_data, input ready);
   modport sink (input valid, csr_index, csr_data, output ready);
endinterface

`default_nettype wire

// ----- design/route_sum_null_meter.sv -----
// route_sum_null_meter: route sample summing, null difference and level meters
// route sample: accept, then peak write; reference sample: square and accumulate each value
//   unless the block is full, then output; end of block: a level result takes two logs for rms,
//   one for peak, a route peak a scan and one log; a log is normalize then bitwise squaring
// one transaction at a time; the output register frees the input side while a result waits
// synchronous reset clears meters, mode 1, route count 0; stale route peaks masked by live bits
`default_nettype none

module route_sum_null_meter #(
   parameter int MAX_ROUTES = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rsm_req_if.sink     req_bus,
   rsm_rsp_if.source   rsp_bus,
   rsm_csr_if.sink     csr_bus
);

   localparam int RW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;

   rsm_pkg::state_type state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [5:0]  count_ff, count_in;
   logic signed [30:0] fsum_l_ff, fsum_l_in, fsum_r_ff, fsum_r_in;
   logic [63:0] energy_ff [3];
   logic [63:0] energy_in [3];
   logic [30:0] speak_ff [3];
   logic [30:0] speak_in [3];
   logic [MAX_ROUTES-1:0] live_ff, live_in;
   logic [15:0] fcount_ff, fcount_in;
   rsm_pkg::sample_type ref_l_ff, ref_l_in, ref_r_ff, ref_r_in;
   logic [RW-1:0] route_ff, route_in;
   logic [23:0] rmag_ff, rmag_in;
   logic [2:0]  q_ff, q_in;
   logic [61:0] mul_ff;
   logic [63:0] lx_ff, lx_in;
   logic [5:0]  le_ff, le_in;
   logic [30:0] lm_ff, lm_in;
   logic [21:0] lr_ff, lr_in, la_ff, la_in;
   logic [3:0]  bit_ff, bit_in;
   logic signed [23:0] lq_ff, lq_in, k_ff, k_in;
   logic signed [47:0] sc_ff, sc_in;
   logic [2:0]  ph_ff, ph_in;
   logic [1:0]  it_ff, it_in;
   logic [5:0]  ri_ff, ri_in;
   logic [23:0] rpk_ff, rpk_in;
   rsm_pkg::level_type rms_ff, rms_in, pkdb_ff, pkdb_in;
   logic [5:0]  livec_ff, livec_in;

   logic        rv_ff, rv_in;
   logic [2:0]  o_kind_ff, o_kind_in;
   logic [4:0]  o_route_ff, o_route_in;
   rsm_pkg::sample_type o_left_ff, o_left_in, o_right_ff, o_right_in;
   rsm_pkg::level_type  o_rms_ff, o_rms_in, o_peak_ff, o_peak_in;
   logic [5:0]  o_live_ff, o_live_in;
   logic        o_last_ff, o_last_in;

   logic [23:0] peak_mem [MAX_ROUTES];
   logic [23:0] mem_rd_ff;
   logic [RW-1:0] mem_addr;
   logic        mem_we;

   logic [5:0]  eff;
   logic [MAX_ROUTES-1:0] cnt_mask, live_m, higher;
   logic        accept, rsp_free;
   logic [RW-1:0] req_route;
   logic signed [31:0] sum32_l, sum32_r, null_l, null_r, sq_val;
   logic [30:0] sq_op, mul_op;
   logic [64:0] eacc;
   logic [31:0] sq_t;
   logic [21:0] lr_done;
   logic signed [47:0] sc_round;
   logic [63:0] cur_energy;
   logic [30:0] cur_peak;
   logic [23:0] old_peak;

   function automatic logic [30:0] mag31(input logic signed [31:0] v);
      logic signed [31:0] n;
      n = -v;
      return v[31] ? n[30:0] : v[30:0];
   endfunction

   function automatic rsm_pkg::sample_type sat24(input logic signed [31:0] v);
      if (v > 32'sd8388607) return 24'sd8388607;
      if (v < -32'sd8388608) return -24'sd8388608;
      return v[23:0];
   endfunction

   function automatic logic signed [30:0] sat31(input logic signed [31:0] v);
      if (v > 32'sd1073741823) return 31'sd1073741823;
      if (v < -32'sd1073741824) return -31'sd1073741824;
      return v[30:0];
   endfunction

   assign eff = (count_ff < 6'(MAX_ROUTES)) ? count_ff : 6'(MAX_ROUTES);

   always_comb begin
      for (int i = 0; i < MAX_ROUTES; i++) begin
         cnt_mask[i] = (6'(i) < eff);
      end
   end

   assign live_m   = live_ff & cnt_mask;
   assign higher   = (live_m >> ri_ff) >> 1;
   assign accept   = req_bus.valid && req_bus.ready;
   assign rsp_free = !rv_ff || rsp_bus.ready;
   assign req_route = RW'(req_bus.route_index);

   assign req_bus.ready = (state_ff == rsm_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign sum32_l = 32'(fsum_l_ff);
   assign sum32_r = 32'(fsum_r_ff);
   assign null_l  = 32'(ref_l_ff) - sum32_l;
   assign null_r  = 32'(ref_r_ff) - sum32_r;

   always_comb begin
      case (q_ff)
         3'd0:    sq_val = 32'(ref_l_ff);
         3'd1:    sq_val = 32'(ref_r_ff);
         3'd2:    sq_val = sum32_l;
         3'd3:    sq_val = sum32_r;
         3'd4:    sq_val = null_l;
         default: sq_val = null_r;
      endcase
   end

   assign sq_op  = mag31(sq_val);
   assign mul_op = (state_ff == rsm_pkg::ST_REF_MUL) ? sq_op : lm_ff;
   assign eacc   = {1'b0, energy_ff[q_ff[2:1]]} + {3'b0, mul_ff};
   assign sq_t   = mul_ff[61:30];
   assign lr_done = sq_t[31] ? (lr_ff | (22'd1 << bit_ff)) : lr_ff;
   assign sc_round = (sc_ff + 48'sd2147483648) >>> 32;
   assign old_peak = live_ff[route_ff] ? mem_rd_ff : 24'd0;

   always_comb begin
      case (it_ff)
         2'd0:    begin cur_energy = energy_ff[0]; cur_peak = speak_ff[0]; end
         2'd1:    begin cur_energy = energy_ff[1]; cur_peak = speak_ff[1]; end
         2'd2:    begin cur_energy = energy_ff[2]; cur_peak = speak_ff[2]; end
         default: begin cur_energy = 64'd0; cur_peak = {7'd0, rpk_ff}; end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      count_in  = count_ff;
      fsum_l_in = fsum_l_ff;
      fsum_r_in = fsum_r_ff;
      energy_in = energy_ff;
      speak_in  = speak_ff;
      live_in   = live_ff;
      fcount_in = fcount_ff;
      ref_l_in  = ref_l_ff;
      ref_r_in  = ref_r_ff;
      route_in  = route_ff;
      rmag_in   = rmag_ff;
      q_in      = q_ff;
      lx_in     = lx_ff;
      le_in     = le_ff;
      lm_in     = lm_ff;
      lr_in     = lr_ff;
      la_in     = la_ff;
      bit_in    = bit_ff;
      lq_in     = lq_ff;
      k_in      = k_ff;
      sc_in     = sc_ff;
      ph_in     = ph_ff;
      it_in     = it_ff;
      ri_in     = ri_ff;
      rpk_in    = rpk_ff;
      rms_in    = rms_ff;
      pkdb_in   = pkdb_ff;
      livec_in  = livec_ff;
      rv_in       = rv_ff && !rsp_bus.ready;
      o_kind_in   = o_kind_ff;
      o_route_in  = o_route_ff;
      o_left_in   = o_left_ff;
      o_right_in  = o_right_ff;
      o_rms_in    = o_rms_ff;
      o_peak_in   = o_peak_ff;
      o_live_in   = o_live_ff;
      o_last_in   = o_last_ff;
      mem_addr    = (state_ff == rsm_pkg::ST_IDLE) ? req_route : ri_ff[RW-1:0];
      mem_we      = 1'b0;

      if (csr_bus.valid) begin
         unique case (csr_bus.csr_index)
            rsm_pkg::REG_MODE:  mode_in = csr_bus.csr_data[1:0];
            rsm_pkg::REG_COUNT: count_in = csr_bus.csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         rsm_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_bus.req_type)
                  rsm_pkg::REQ_ROUTE: begin
                     if ({1'b0, req_bus.route_index} < eff) begin
                        fsum_l_in = sat31(sum32_l + 32'(req_bus.left_sample));
                        fsum_r_in = sat31(sum32_r + 32'(req_bus.right_sample));
                        route_in  = req_route;
                        rmag_in   = 24'(mag31(32'(req_bus.left_sample)));
                        if (24'(mag31(32'(req_bus.right_sample))) > rmag_in)
                           rmag_in = 24'(mag31(32'(req_bus.right_sample)));
                        state_in  = rsm_pkg::ST_RT_WR;
                     end
                  end
                  rsm_pkg::REQ_REF: begin
                     ref_l_in = req_bus.ref_present ? req_bus.left_sample : '0;
                     ref_r_in = req_bus.ref_present ? req_bus.right_sample : '0;
                     q_in     = 3'd0;
                     state_in = (fcount_ff < rsm_pkg::MAX_FRAMES) ? rsm_pkg::ST_REF_MUL
                                                                  : rsm_pkg::ST_REF_OUT;
                  end
                  rsm_pkg::REQ_EOB: begin
                     livec_in = 6'($countones(live_m));
                     it_in    = 2'd0;
                     ph_in    = 3'd0;
                     ri_in    = 6'd0;
                     fsum_l_in = '0;
                     fsum_r_in = '0;
                     state_in = rsm_pkg::ST_E_PREP;
                  end
                  default: ;
               endcase
            end
         end
         rsm_pkg::ST_RT_WR: begin
            mem_addr = route_ff;
            // first sample of a route in this block overwrites the stale entry
            if (!live_ff[route_ff] || rmag_ff > old_peak) mem_we = 1'b1;
            live_in[route_ff] = 1'b1;
            state_in = rsm_pkg::ST_IDLE;
         end
         rsm_pkg::ST_REF_MUL: begin
            if (sq_op > speak_ff[q_ff[2:1]]) speak_in[q_ff[2:1]] = sq_op;
            state_in = rsm_pkg::ST_REF_ACC;
         end
         rsm_pkg::ST_REF_ACC: begin
            // saturate per square; identical to saturating the pair sum
            energy_in[q_ff[2:1]] = eacc[64] ? '1 : eacc[63:0];
            if (q_ff == 3'd5) begin
               fcount_in = fcount_ff + 16'd1;
               state_in  = rsm_pkg::ST_REF_OUT;
            end else begin
               q_in     = q_ff + 3'd1;
               state_in = rsm_pkg::ST_REF_MUL;
            end
         end
         rsm_pkg::ST_REF_OUT: begin
            if (rsp_free) begin
               rv_in      = 1'b1;
               o_kind_in  = rsm_pkg::KIND_AUDIO;
               o_route_in = '0;
               o_rms_in   = '0;
               o_peak_in  = '0;
               o_live_in  = '0;
               o_last_in  = 1'b1;
               case (mode_ff)
                  rsm_pkg::MODE_REF: begin
                     o_left_in  = ref_l_ff;
                     o_right_in = ref_r_ff;
                  end
                  rsm_pkg::MODE_SUM: begin
                     o_left_in  = sat24(sum32_l);
                     o_right_in = sat24(sum32_r);
                  end
                  default: begin
                     o_left_in  = sat24(null_l);
                     o_right_in = sat24(null_r);
                  end
               endcase
               fsum_l_in = '0;
               fsum_r_in = '0;
               state_in  = rsm_pkg::ST_IDLE;
            end
         end
         rsm_pkg::ST_E_PREP: begin
            case (ph_ff)
               3'd0: begin
                  if (cur_energy == 64'd0 || fcount_ff == 16'd0) begin
                     rms_in = rsm_pkg::DB_FLOOR;
                     ph_in  = 3'd3;
                  end else begin
                     lx_in    = cur_energy;
                     le_in    = 6'd63;
                     state_in = rsm_pkg::ST_NORM;
                  end
               end
               3'd1: begin
                  lx_in    = {47'd0, fcount_ff, 1'b0};
                  le_in    = 6'd63;
                  state_in = rsm_pkg::ST_NORM;
               end
               3'd2: begin
                  lq_in    = $signed({2'b0, la_ff}) - $signed({2'b0, lr_ff}) - rsm_pkg::RMS_BIAS;
                  k_in     = rsm_pkg::K_POW;
                  state_in = rsm_pkg::ST_SC_MUL;
               end
               3'd3: begin
                  if (cur_peak == 31'd0) begin
                     pkdb_in = rsm_pkg::DB_FLOOR;
                     ph_in   = 3'd5;
                  end else begin
                     lx_in    = {33'd0, cur_peak};
                     le_in    = 6'd63;
                     state_in = rsm_pkg::ST_NORM;
                  end
               end
               3'd4: begin
                  lq_in    = $signed({2'b0, lr_ff}) - rsm_pkg::PEAK_BIAS;
                  k_in     = rsm_pkg::K_AMP;
                  state_in = rsm_pkg::ST_SC_MUL;
               end
               default: begin
                  if (rsp_free) begin
                     rv_in      = 1'b1;
                     o_kind_in  = (it_ff == 2'd3) ? rsm_pkg::KIND_ROUTE
                                                  : rsm_pkg::KIND_REF + 3'(it_ff);
                     o_route_in = (it_ff == 2'd3) ? ri_ff[4:0] : 5'd0;
                     o_left_in  = '0;
                     o_right_in = '0;
                     o_rms_in   = rms_ff;
                     o_peak_in  = pkdb_ff;
                     o_live_in  = livec_ff;
                     o_last_in  = (it_ff == 2'd2 && live_m == '0) ||
                                  (it_ff == 2'd3 && higher == '0);
                     ph_in      = 3'd0;
                     if (o_last_in) begin
                        // end of block: clear all meters
                        for (int s = 0; s < 3; s++) begin
                           energy_in[s] = '0;
                           speak_in[s]  = '0;
                        end
                        live_in   = '0;
                        fcount_in = '0;
                        state_in  = rsm_pkg::ST_IDLE;
                     end else if (it_ff < 2'd2) begin
                        it_in = it_ff + 2'd1;
                     end else if (it_ff == 2'd2) begin
                        it_in    = 2'd3;
                        ri_in    = 6'd0;
                        state_in = rsm_pkg::ST_E_NEXT;
                     end else begin
                        ri_in    = ri_ff + 6'd1;
                        state_in = rsm_pkg::ST_E_NEXT;
                     end
                  end
               end
            endcase
         end
         rsm_pkg::ST_E_NEXT: begin
            // scan for the next live route; one is known to remain
            if (((live_m >> ri_ff) & {{(MAX_ROUTES-1){1'b0}}, 1'b1}) != '0) begin
               state_in = rsm_pkg::ST_E_RDW;
            end else begin
               ri_in = ri_ff + 6'd1;
            end
         end
         rsm_pkg::ST_E_RDW: begin
            rpk_in   = mem_rd_ff;
            rms_in   = rsm_pkg::DB_FLOOR;
            ph_in    = 3'd3;
            state_in = rsm_pkg::ST_E_PREP;
         end
         rsm_pkg::ST_NORM: begin
            if (le_ff != 6'd0 && !lx_ff[63]) begin
               lx_in = {lx_ff[62:0], 1'b0};
               le_in = le_ff - 6'd1;
            end else begin
               lm_in    = lx_ff[63:33];
               lr_in    = {le_ff, 16'd0};
               bit_in   = 4'd15;
               state_in = rsm_pkg::ST_SQ_MUL;
            end
         end
         rsm_pkg::ST_SQ_MUL: begin
            state_in = rsm_pkg::ST_SQ_UPD;
         end
         rsm_pkg::ST_SQ_UPD: begin
            lm_in = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
            lr_in = lr_done;
            if (bit_ff == 4'd0) begin
               if (ph_ff == 3'd0) la_in = lr_done;
               ph_in    = ph_ff + 3'd1;
               state_in = rsm_pkg::ST_E_PREP;
            end else begin
               bit_in   = bit_ff - 4'd1;
               state_in = rsm_pkg::ST_SQ_MUL;
            end
         end
         rsm_pkg::ST_SC_MUL: begin
            sc_in    = 48'(lq_ff) * 48'(k_ff);
            state_in = rsm_pkg::ST_SC_FIN;
         end
         rsm_pkg::ST_SC_FIN: begin
            if (ph_ff == 3'd2) begin
               rms_in = (sc_round < 48'(rsm_pkg::DB_FLOOR)) ? rsm_pkg::DB_FLOOR : sc_round[11:0];
               ph_in  = 3'd3;
            end else begin
               pkdb_in = (sc_round < 48'(rsm_pkg::DB_FLOOR)) ? rsm_pkg::DB_FLOOR : sc_round[11:0];
               ph_in   = 3'd5;
            end
            state_in = rsm_pkg::ST_E_PREP;
         end
         default: state_in = rsm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mem_rd_ff <= peak_mem[mem_addr];
      if (mem_we) peak_mem[mem_addr] <= rmag_ff;
   end

   always_ff @(posedge clock) begin
      mul_ff     <= {31'd0, mul_op} * {31'd0, mul_op};
      ref_l_ff   <= ref_l_in;
      ref_r_ff   <= ref_r_in;
      route_ff   <= route_in;
      rmag_ff    <= rmag_in;
      q_ff       <= q_in;
      lx_ff      <= lx_in;
      le_ff      <= le_in;
      lm_ff      <= lm_in;
      lr_ff      <= lr_in;
      la_ff      <= la_in;
      bit_ff     <= bit_in;
      lq_ff      <= lq_in;
      k_ff       <= k_in;
      sc_ff      <= sc_in;
      ph_ff      <= ph_in;
      it_ff      <= it_in;
      ri_ff      <= ri_in;
      rpk_ff     <= rpk_in;
      rms_ff     <= rms_in;
      pkdb_ff    <= pkdb_in;
      livec_ff   <= livec_in;
      o_kind_ff  <= o_kind_in;
      o_route_ff <= o_route_in;
      o_left_ff  <= o_left_in;
      o_right_ff <= o_right_in;
      o_rms_ff   <= o_rms_in;
      o_peak_ff  <= o_peak_in;
      o_live_ff  <= o_live_in;
      o_last_ff  <= o_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rsm_pkg::ST_IDLE;
         mode_ff   <= rsm_pkg::MODE_SUM;
         count_ff  <= '0;
         fsum_l_ff <= '0;
         fsum_r_ff <= '0;
         for (int s = 0; s < 3; s++) begin
            energy_ff[s] <= '0;
            speak_ff[s]  <= '0;
         end
         live_ff   <= '0;
         fcount_ff <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         fsum_l_ff <= fsum_l_in;
         fsum_r_ff <= fsum_r_in;
         energy_ff <= energy_in;
         speak_ff  <= speak_in;
         live_ff   <= live_in;
         fcount_ff <= fcount_in;
         rv_ff     <= rv_in;
      end
   end

   assign rsp_bus.valid      = rv_ff;
   assign rsp_bus.kind       = o_kind_ff;
   assign rsp_bus.route_out  = o_route_ff;
   assign rsp_bus.out_left   = o_left_ff;
   assign rsp_bus.out_right  = o_right_ff;
   assign rsp_bus.rms_db     = o_rms_ff;
   assign rsp_bus.peak_db    = o_peak_ff;
   assign rsp_bus.live_count = o_live_ff;
   assign rsp_bus.last       = o_last_ff;

endmodule

`default_nettype wire

// ----- design/rsm_check.sv -----
// rsm_check: port-level assertions for route_sum_null_meter, bound to the top level
// depends on rsm_pkg and route_sum_null_meter
`default_nettype none

module rsm_check (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_kind,
   input wire logic [23:0] rsp_left,
   input wire logic [23:0] rsp_right,
   input wire logic signed [11:0] rsp_rms,
   input wire logic       rsp_last
);

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_left) && $stable(rsp_last))
      else $error("response payload changed while stalled");

   a_audio_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == rsm_pkg::KIND_AUDIO |-> rsp_last)
      else $error("audio transaction not marked last");

   a_meter_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != rsm_pkg::KIND_AUDIO |-> rsp_left == 24'd0 && rsp_right == 24'd0)
      else $error("meter transaction carries audio");

   a_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != rsm_pkg::KIND_AUDIO |-> rsp_rms >= rsm_pkg::DB_FLOOR)
      else $error("rms level below floor");

endmodule

bind route_sum_null_meter rsm_check u_rsm_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_kind  (rsp_bus.kind),
   .rsp_left  (rsp_bus.out_left),
   .rsp_right (rsp_bus.out_right),
   .rsp_rms   (rsp_bus.rms_db),
   .rsp_last  (rsp_bus.last)
);

`default_nettype wire
